// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro places one labeled concurrent assertion on the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked only outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication with no reset gating, for reset behavior itself.
`define ASSERT_NEXT_NR(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dfr_pkg.sv =====
// Types and constants for the length-prefixed deframer.
// No dependencies; imported by every RTL module of the block.
package dfr_pkg;

  localparam int unsigned LEN_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 32'hffff_ffff;

  // Both internal queues hold two entries.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;
  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = 2'(Q_DEPTH);

  localparam logic [PADDR_W-1:0] ADDR_MAX_LENGTH = '0;

  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_XPORT  = 2'd2;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_BEGIN,
    OP_ABORT
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_PROGRESS,
    ST_COMPLETE,
    ST_ZERO,
    ST_RANGE,
    ST_TRANSPORT
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              has_payload;
    logic              end_of_message;
    status_t           status;
  } res_t;

endpackage

// ===== sv/length_prefixed_deframer.sv =====
// Length-prefixed deframer top level: APB registers, front end, back end.
// Throughput: one input beat per cycle while full is low, one result beat per cycle while the result queue is not full.
// Path: an input beat is registered in the command queue, then the back end executes it
// once the result queue has room, updating its state and registering the result in the result queue.
// Reset (synchronous rst): both queues empty, receiver idle, max_length all ones.
module length_prefixed_deframer import dfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [KIND_W-1:0]  kind,
  input  logic [BYTE_W-1:0]  data_byte,
  output logic               empty,
  input  logic               pop,
  output logic [BYTE_W-1:0]  payload_byte,
  output logic               has_payload,
  output logic               end_of_message,
  output logic [2:0]         status
);

  logic [LEN_W-1:0] max_length;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;
  res_t             res;

  dfr_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_length (max_length)
  );

  dfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  dfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .max_length (max_length),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  assign payload_byte   = res.payload_byte;
  assign has_payload    = res.has_payload;
  assign end_of_message = res.end_of_message;
  assign status         = 3'(res.status);

endmodule

// ===== sv/dfr_cfg.sv =====
// APB register file of the deframer: holds max_length.
// Depends on dfr_pkg.
module dfr_cfg import dfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [LEN_W-1:0]   max_length
);

  logic hit;

  assign hit    = (paddr == ADDR_MAX_LENGTH);
  assign pready = 1'b1;
  assign prdata = hit ? max_length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_length <= pwdata;
    end
  end

endmodule

// ===== sv/dfr_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
// Depends on dfr_pkg.
module dfr_front import dfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic [Q_CNT_W-1:0] count_next;
  cmd_t               cls;
  logic               cls_valid;
  logic               enq;
  logic               deq;

  // Unused kind codes are consumed here and never reach the back end.
  always_comb begin
    cls.data  = data_byte;
    cls.op    = OP_DATA;
    cls_valid = 1'b1;
    case (kind)
      KIND_DATA:  cls.op = OP_DATA;
      KIND_BEGIN: cls.op = OP_BEGIN;
      KIND_XPORT: cls.op = OP_ABORT;
      default:    cls_valid = 1'b0;
    endcase
  end

  assign full      = (count == Q_FULL_CNT);
  assign cmd_valid = (count != '0);
  assign cmd       = entry[rd_ptr];
  assign enq       = push && !full && cls_valid;
  assign deq       = cmd_pop && cmd_valid;

  always_comb begin
    count_next = count;
    if (enq && !deq) begin
      count_next = count + 1'b1;
    end else if (deq && !enq) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      entry[wr_ptr] <= cls;
    end
  end

endmodule

// ===== sv/dfr_back.sv =====
// Back end: header assembly, length checks, payload counting, result queue.
// Depends on dfr_pkg.
module dfr_back import dfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  logic [LEN_W-1:0] max_length,
  input  logic             pop,
  output logic             empty,
  output res_t             res
);

  phase_t             phase;
  phase_t             phase_next;
  logic [1:0]         hdr_cnt;
  logic [1:0]         hdr_cnt_next;
  logic [LEN_W-1:0]   msg_len;
  logic [LEN_W-1:0]   msg_len_next;
  logic [LEN_W-1:0]   rx_cnt;
  logic [LEN_W-1:0]   rx_cnt_next;
  logic [LEN_W-1:0]   len_shift;
  logic [LEN_W-1:0]   rx_inc;
  res_t               gen;
  logic               gen_valid;

  res_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic [Q_CNT_W-1:0] count_next;
  logic               enq;
  logic               deq;

  // A command is executed only when the result queue has a free slot.
  assign cmd_pop   = cmd_valid && (count != Q_FULL_CNT);
  assign len_shift = {msg_len[LEN_W-BYTE_W-1:0], cmd.data};
  assign rx_inc    = rx_cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      hdr_cnt <= '0;
      msg_len <= '0;
      rx_cnt  <= '0;
    end else begin
      phase   <= phase_next;
      hdr_cnt <= hdr_cnt_next;
      msg_len <= msg_len_next;
      rx_cnt  <= rx_cnt_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    hdr_cnt_next       = hdr_cnt;
    msg_len_next       = msg_len;
    rx_cnt_next        = rx_cnt;
    gen_valid          = 1'b0;
    gen.payload_byte   = '0;
    gen.has_payload    = 1'b0;
    gen.end_of_message = 1'b1;
    gen.status         = ST_PROGRESS;
    if (cmd_pop) begin
      case (cmd.op)
        OP_BEGIN: begin
          phase_next   = PH_HEADER;
          hdr_cnt_next = '0;
          msg_len_next = '0;
          rx_cnt_next  = '0;
        end
        OP_ABORT: begin
          if (phase != PH_IDLE) begin
            phase_next = PH_IDLE;
            gen_valid  = 1'b1;
            gen.status = ST_TRANSPORT;
          end
        end
        OP_DATA: begin
          case (phase)
            PH_HEADER: begin
              msg_len_next = len_shift;
              if (hdr_cnt != 2'd3) begin
                hdr_cnt_next = hdr_cnt + 1'b1;
              end else begin
                hdr_cnt_next = '0;
                if (len_shift == '0) begin
                  phase_next = PH_IDLE;
                  gen_valid  = 1'b1;
                  gen.status = ST_ZERO;
                end else if (len_shift > max_length) begin
                  phase_next = PH_IDLE;
                  gen_valid  = 1'b1;
                  gen.status = ST_RANGE;
                end else begin
                  phase_next  = PH_PAYLOAD;
                  rx_cnt_next = '0;
                end
              end
            end
            PH_PAYLOAD: begin
              rx_cnt_next      = rx_inc;
              gen_valid        = 1'b1;
              gen.payload_byte = cmd.data;
              gen.has_payload  = 1'b1;
              if (rx_inc == msg_len) begin
                phase_next = PH_IDLE;
                gen.status = ST_COMPLETE;
              end else begin
                gen.end_of_message = 1'b0;
              end
            end
            default: begin
              // idle: byte dropped
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Two-entry result queue toward the pop side.
  assign empty = (count == '0);
  assign res   = entry[rd_ptr];
  assign enq   = gen_valid;
  assign deq   = pop && !empty;

  always_comb begin
    count_next = count;
    if (enq && !deq) begin
      count_next = count + 1'b1;
    end else if (deq && !enq) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      entry[wr_ptr] <= gen;
    end
  end

endmodule

// ===== sv/dfr_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       pready,
  input logic [7:0] payload_byte,
  input logic       has_payload,
  input logic       end_of_message,
  input logic [2:0] status
);

  `ASSERT_NEXT_NR(a_reset_clears, clk, rst, empty && !full, "queues not empty after reset")
  `ASSERT_IMPLIES(a_eom_status, clk, rst, !empty, end_of_message == (status != 3'd0) && pready, "end flag disagrees with status")
  `ASSERT_IMPLIES(a_no_payload, clk, rst, !empty && !has_payload, payload_byte == 8'd0 && status != 3'd1, "status-only result carries payload")
  `ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(payload_byte) && $stable(status), "waiting result changed")

endmodule

bind length_prefixed_deframer dfr_checker u_dfr_checker (.*);
